FILE: rtl/vdms_pkg.sv
// Package with shared types and constants for the drive mode sequencer.
`default_nettype none
package vdms_pkg;

  localparam int PERIOD_W  = 10;
  localparam int WAIT_W    = 16;
  localparam int ELAPSED_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HV_WAIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HV_TIMEOUT  = 2'd2;

  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 10'd10;
  localparam logic [WAIT_W-1:0]   HV_WAIT_RST     = 16'd1000;
  localparam logic [WAIT_W-1:0]   HV_TIMEOUT_RST  = 16'd5000;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_SET  = 2'd1;

  typedef enum logic [3:0] {
    MODE_INIT        = 4'd0,
    MODE_LV_STARTUP  = 4'd1,
    MODE_LV_READY    = 4'd2,
    MODE_HV_ACTIVE   = 4'd3,
    MODE_HV_CHARGING = 4'd4,
    MODE_NEUTRAL     = 4'd5,
    MODE_FORWARD     = 4'd6,
    MODE_REVERSE     = 4'd7,
    MODE_FAULT       = 4'd8
  } mode_t;

  typedef struct packed {
    logic [1:0] fault_status;
    logic       sense_valid;
    logic       button_level;
    logic       inverter_ready;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] mode_code;
    logic       inverter_enable_pulse;
    logic       motor_reverse;
    logic       torque_enable;
  } out_beat_t;

  // Control from the mode sequencer to the tick timer.
  typedef struct packed {
    logic step;
    logic restart;
  } timer_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/vdms_timer.sv
// Saturating tick counter and saturating elapsed-time product.
`default_nettype none
module vdms_timer #(
  parameter int TICK_COUNT_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire vdms_pkg::timer_ctl_t           ctl,
  input  wire logic [vdms_pkg::PERIOD_W-1:0]  tick_period,
  output logic      [vdms_pkg::ELAPSED_W-1:0] elapsed
);

  localparam int PROD_W = TICK_COUNT_WIDTH + vdms_pkg::PERIOD_W;

  logic [TICK_COUNT_WIDTH-1:0] count;
  logic [TICK_COUNT_WIDTH-1:0] count_next;
  logic [PROD_W-1:0]           prod;
  logic [63:0]                 prod_wide;

  always_comb begin
    count_next = count;
    if (ctl.restart) begin
      count_next = '0;
    end else if (count != {TICK_COUNT_WIDTH{1'b1}}) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.step) begin
      count <= count_next;
    end
  end

  assign prod      = PROD_W'(tick_period) * PROD_W'(count);
  assign prod_wide = 64'(prod);
  // Clamp to 32 bits of milliseconds.
  assign elapsed   = (|prod_wide[63:32]) ? {vdms_pkg::ELAPSED_W{1'b1}} : prod_wide[31:0];

endmodule
`default_nettype wire

FILE: rtl/vdms_fsm.sv
// Drive mode state machine with direction, torque and button history.
`default_nettype none
module vdms_fsm (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           step,
  input  wire vdms_pkg::in_beat_t             beat,
  input  wire logic [vdms_pkg::ELAPSED_W-1:0] elapsed,
  input  wire logic [vdms_pkg::WAIT_W-1:0]    hv_wait,
  input  wire logic [vdms_pkg::WAIT_W-1:0]    hv_timeout,
  output vdms_pkg::timer_ctl_t                timer_ctl,
  output vdms_pkg::out_beat_t                 result,
  output vdms_pkg::mode_t                     mode
);

  vdms_pkg::mode_t mode_next;
  logic button_prev, button_prev_next;
  logic direction, direction_next;
  logic torque, torque_next;
  logic pulse;
  logic edge_seen;
  logic no_fault;
  logic wait_done;
  logic charge_late;

  assign edge_seen   = beat.sense_valid & beat.button_level & ~button_prev;
  assign no_fault    = (beat.fault_status == vdms_pkg::FAULT_NONE);
  assign wait_done   = (elapsed >= vdms_pkg::ELAPSED_W'(hv_wait));
  assign charge_late = (elapsed > vdms_pkg::ELAPSED_W'(hv_timeout));

  // Next mode.
  always_comb begin
    mode_next = mode;
    unique case (mode)
      vdms_pkg::MODE_INIT: begin
        mode_next = vdms_pkg::MODE_LV_STARTUP;
      end
      vdms_pkg::MODE_LV_STARTUP: begin
        if (beat.fault_status == vdms_pkg::FAULT_SET) begin
          mode_next = vdms_pkg::MODE_FAULT;
        end else if (no_fault) begin
          mode_next = vdms_pkg::MODE_LV_READY;
        end
      end
      vdms_pkg::MODE_LV_READY: begin
        if (!no_fault) mode_next = vdms_pkg::MODE_FAULT;
        else if (edge_seen) mode_next = vdms_pkg::MODE_HV_ACTIVE;
      end
      vdms_pkg::MODE_HV_ACTIVE: begin
        if (!no_fault) mode_next = vdms_pkg::MODE_FAULT;
        else if (wait_done) mode_next = vdms_pkg::MODE_HV_CHARGING;
      end
      vdms_pkg::MODE_HV_CHARGING: begin
        priority if (!no_fault) begin
          mode_next = vdms_pkg::MODE_FAULT;
        end else if (beat.sense_valid && beat.inverter_ready) begin
          mode_next = vdms_pkg::MODE_NEUTRAL;
        end else if (beat.sense_valid && charge_late) begin
          mode_next = vdms_pkg::MODE_FAULT;
        end
      end
      vdms_pkg::MODE_NEUTRAL: begin
        if (!no_fault) mode_next = vdms_pkg::MODE_FAULT;
        else if (edge_seen) mode_next = vdms_pkg::MODE_FORWARD;
      end
      vdms_pkg::MODE_FORWARD: begin
        if (!no_fault) mode_next = vdms_pkg::MODE_FAULT;
        else if (edge_seen) mode_next = vdms_pkg::MODE_REVERSE;
      end
      vdms_pkg::MODE_REVERSE: begin
        if (!no_fault) mode_next = vdms_pkg::MODE_FAULT;
        else if (edge_seen) mode_next = vdms_pkg::MODE_NEUTRAL;
      end
      vdms_pkg::MODE_FAULT: begin
        mode_next = vdms_pkg::MODE_FAULT;
      end
      default: begin
        mode_next = vdms_pkg::MODE_INIT;
      end
    endcase
  end

  // Outputs and side registers.
  always_comb begin
    pulse            = 1'b0;
    direction_next   = direction;
    torque_next      = torque;
    button_prev_next = button_prev;
    unique case (mode)
      vdms_pkg::MODE_HV_ACTIVE: begin
        pulse = no_fault & wait_done;
      end
      vdms_pkg::MODE_LV_READY, vdms_pkg::MODE_NEUTRAL,
      vdms_pkg::MODE_FORWARD, vdms_pkg::MODE_REVERSE: begin
        if (no_fault) begin
          if (edge_seen) begin
            if (mode == vdms_pkg::MODE_NEUTRAL) begin
              direction_next = 1'b0;
              torque_next    = 1'b1;
            end else if (mode == vdms_pkg::MODE_FORWARD) begin
              direction_next = 1'b1;
              torque_next    = 1'b1;
            end else if (mode == vdms_pkg::MODE_REVERSE) begin
              direction_next = 1'b0;
              torque_next    = 1'b0;
            end
          end
          if (beat.sense_valid) button_prev_next = beat.button_level;
        end
      end
      vdms_pkg::MODE_FAULT: begin
        direction_next = 1'b0;
        torque_next    = 1'b0;
      end
      default: begin
        pulse = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= vdms_pkg::MODE_INIT;
      button_prev <= 1'b0;
      direction   <= 1'b0;
      torque      <= 1'b0;
    end else if (step) begin
      mode        <= mode_next;
      button_prev <= button_prev_next;
      direction   <= direction_next;
      torque      <= torque_next;
    end
  end

  assign timer_ctl.step    = step;
  assign timer_ctl.restart = (mode_next != mode);

  assign result.mode_code             = 4'(mode_next);
  assign result.inverter_enable_pulse = pulse;
  assign result.motor_reverse         = direction_next;
  assign result.torque_enable         = torque_next;

endmodule
`default_nettype wire

FILE: rtl/vehicle_drive_mode_sequencer.sv
// Top level of the vehicle drive mode sequencer: beat registers, config, assertions.
//
//   Channel  | Signals                          | Direction | Beat
//   ---------+----------------------------------+-----------+---------------------------
//   in       | in_valid, in_stall, in_data      | into      | one control tick
//   out      | out_valid, out_stall, out_data   | out of    | mode and drive outputs
//   cfg      | cfg_we, cfg_index, cfg_data      | into      | one register write
//
// An accepted in beat passes through the input register, then through the mode
// logic (one 10-bit period x count multiply and a compare) into the output
// register. One beat is taken every cycle while out is not stalled; the
// output register frees in the same cycle it is drained, so a stall on out only
// backs up into in_stall when both stages are full. Reset (rst, synchronous)
// empties both stages, puts the sequencer in init and loads the config defaults.
`default_nettype none
module vehicle_drive_mode_sequencer #(
  parameter int TICK_COUNT_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire vdms_pkg::in_beat_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output vdms_pkg::out_beat_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [vdms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [vdms_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers.
  logic [vdms_pkg::PERIOD_W-1:0] tick_period;
  logic [vdms_pkg::WAIT_W-1:0]   hv_wait;
  logic [vdms_pkg::WAIT_W-1:0]   hv_timeout;

  // Input stage.
  logic                s1_valid;
  vdms_pkg::in_beat_t  s1_data;
  logic                advance;

  logic [vdms_pkg::ELAPSED_W-1:0] elapsed;
  vdms_pkg::timer_ctl_t           timer_ctl;
  vdms_pkg::out_beat_t            result;
  vdms_pkg::mode_t                mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= vdms_pkg::TICK_PERIOD_RST;
      hv_wait     <= vdms_pkg::HV_WAIT_RST;
      hv_timeout  <= vdms_pkg::HV_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vdms_pkg::CFG_TICK_PERIOD: tick_period <= cfg_data[vdms_pkg::PERIOD_W-1:0];
        vdms_pkg::CFG_HV_WAIT:     hv_wait     <= cfg_data;
        vdms_pkg::CFG_HV_TIMEOUT:  hv_timeout  <= cfg_data;
        default: begin
          // Unknown index: drop the write.
        end
      endcase
    end
  end

  // Advance the held tick when the output register is empty or draining.
  assign advance  = s1_valid & (~out_valid | ~out_stall);
  assign in_stall = s1_valid & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data <= in_data;
    end
  end

  vdms_timer #(
    .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
  ) u_timer (
    .clk         (clk),
    .rst         (rst),
    .ctl         (timer_ctl),
    .tick_period (tick_period),
    .elapsed     (elapsed)
  );

  vdms_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .beat       (s1_data),
    .elapsed    (elapsed),
    .hv_wait    (hv_wait),
    .hv_timeout (hv_timeout),
    .timer_ctl  (timer_ctl),
    .result     (result),
    .mode       (mode)
  );

  // Output register: load on advance, clear once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // The enable pulse only ever reports entry into charging.
  a_pulse_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.inverter_enable_pulse |->
      out_data.mode_code == 4'(vdms_pkg::MODE_HV_CHARGING))
    else $error("inverter enable pulse outside charging entry");

  // Torque is only on in forward or reverse, or on the beat that enters fault
  // from a drive mode (the drive outputs hold for that one beat).
  a_torque_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.torque_enable |->
      out_data.mode_code == 4'(vdms_pkg::MODE_FORWARD) ||
      out_data.mode_code == 4'(vdms_pkg::MODE_REVERSE) ||
      out_data.mode_code == 4'(vdms_pkg::MODE_FAULT))
    else $error("torque enabled outside a drive mode");

  // Fault is terminal.
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    mode == vdms_pkg::MODE_FAULT |=> mode == vdms_pkg::MODE_FAULT)
    else $error("sequencer left the fault mode");

  // Sequencer state only moves when a beat advances.
  a_mode_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(mode))
    else $error("mode changed without a beat");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for the drive mode sequencer: directed plan, random drive cycles.
module tb_top;

  // Fault codes the package leaves unnamed, and the register index the block ignores.
  localparam logic [1:0] FAULT_UNDECIDED = 2'd2;
  localparam logic [1:0] FAULT_ODD       = 2'd3;
  localparam logic [vdms_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int PHASE_TICKS  = 510;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_PRINTS   = 40;

  typedef enum logic [1:0] {ROW_TICK, ROW_CHECK, ROW_WRITE} row_kind_t;

  // One line of the directed plan: a tick (checked by the predictor or against a
  // typed-in result) or a register write done while the block is idle.
  typedef struct packed {
    row_kind_t                       kind;
    vdms_pkg::in_beat_t              tick;
    vdms_pkg::out_beat_t             want;
    logic [vdms_pkg::CFG_IDX_W-1:0]  idx;
    logic [vdms_pkg::CFG_DATA_W-1:0] val;
  } plan_row_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  vdms_pkg::in_beat_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  vdms_pkg::out_beat_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [vdms_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [vdms_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // Predictor copy of the configuration and of the sequencer state.
  logic [vdms_pkg::PERIOD_W-1:0] period_ms   = vdms_pkg::TICK_PERIOD_RST;
  logic [vdms_pkg::WAIT_W-1:0]   wait_ms     = vdms_pkg::HV_WAIT_RST;
  logic [vdms_pkg::WAIT_W-1:0]   timeout_ms  = vdms_pkg::HV_TIMEOUT_RST;
  vdms_pkg::mode_t               cur_mode    = vdms_pkg::MODE_INIT;
  logic [31:0]                   mode_ticks  = '0;
  logic                          prev_button = 1'b0;
  logic                          rev_dir     = 1'b0;
  logic                          torque_on   = 1'b0;

  vdms_pkg::out_beat_t expected_drive[$];
  plan_row_t plan[$];

  int errors        = 0;
  int ticks_sent    = 0;
  int results_seen  = 0;
  int writes_done   = 0;
  int mode_changes  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Button pattern for the random part: held runs of press and release.
  logic btn_level = 1'b0;
  int   btn_run   = 0;

  vehicle_drive_mode_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Elapsed time in the current mode: period times count, saturated to 32 bits.
  function automatic logic [31:0] elapsed_ms();
    logic [41:0] prod;
    prod = period_ms * mode_ticks;
    return (|prod[41:32]) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  // Advance the predicted sequencer by one tick and return the out beat it causes.
  task automatic step_sequencer(input vdms_pkg::in_beat_t b, output vdms_pkg::out_beat_t r);
    vdms_pkg::mode_t nxt;
    logic  pulse;
    logic  rise;
    logic  faulted;
    nxt     = cur_mode;
    pulse   = 1'b0;
    rise    = b.sense_valid && b.button_level && !prev_button;
    faulted = (b.fault_status != vdms_pkg::FAULT_NONE);
    case (cur_mode)
      vdms_pkg::MODE_INIT: nxt = vdms_pkg::MODE_LV_STARTUP;
      vdms_pkg::MODE_LV_STARTUP: begin
        // Undecided status holds; only a plain fault code trips here.
        if (b.fault_status == vdms_pkg::FAULT_SET) nxt = vdms_pkg::MODE_FAULT;
        else if (!faulted) nxt = vdms_pkg::MODE_LV_READY;
      end
      vdms_pkg::MODE_HV_ACTIVE: begin
        if (faulted) nxt = vdms_pkg::MODE_FAULT;
        else if (elapsed_ms() >= wait_ms) begin
          nxt   = vdms_pkg::MODE_HV_CHARGING;
          pulse = 1'b1;
        end
      end
      vdms_pkg::MODE_HV_CHARGING: begin
        // Inverter ready wins over the timeout; both need readable sense data.
        if (faulted) nxt = vdms_pkg::MODE_FAULT;
        else if (b.sense_valid && b.inverter_ready) nxt = vdms_pkg::MODE_NEUTRAL;
        else if (b.sense_valid && elapsed_ms() > timeout_ms) nxt = vdms_pkg::MODE_FAULT;
      end
      vdms_pkg::MODE_LV_READY, vdms_pkg::MODE_NEUTRAL,
      vdms_pkg::MODE_FORWARD, vdms_pkg::MODE_REVERSE: begin
        if (faulted) nxt = vdms_pkg::MODE_FAULT;
        else begin
          if (rise) begin
            case (cur_mode)
              vdms_pkg::MODE_LV_READY: nxt = vdms_pkg::MODE_HV_ACTIVE;
              vdms_pkg::MODE_NEUTRAL: begin
                nxt       = vdms_pkg::MODE_FORWARD;
                rev_dir   = 1'b0;
                torque_on = 1'b1;
              end
              vdms_pkg::MODE_FORWARD: begin
                nxt       = vdms_pkg::MODE_REVERSE;
                rev_dir   = 1'b1;
                torque_on = 1'b1;
              end
              default: begin
                nxt       = vdms_pkg::MODE_NEUTRAL;
                rev_dir   = 1'b0;
                torque_on = 1'b0;
              end
            endcase
          end
          if (b.sense_valid) prev_button = b.button_level;
        end
      end
      vdms_pkg::MODE_FAULT: begin
        rev_dir   = 1'b0;
        torque_on = 1'b0;
      end
      default: nxt = vdms_pkg::MODE_INIT;
    endcase
    if (mode_ticks != '1) mode_ticks++;
    if (nxt != cur_mode) begin
      mode_ticks = '0;
      cur_mode   = nxt;
      mode_changes++;
    end
    r = '{mode_code: cur_mode, inverter_enable_pulse: pulse,
          motor_reverse: rev_dir, torque_enable: torque_on};
  endtask

  function automatic vdms_pkg::in_beat_t tk(logic [1:0] f, logic sv, logic bt, logic inv);
    return '{fault_status: f, sense_valid: sv, button_level: bt, inverter_ready: inv};
  endfunction

  function automatic vdms_pkg::out_beat_t ob(vdms_pkg::mode_t m, logic pulse, logic rev,
                                             logic tq);
    return '{mode_code: m, inverter_enable_pulse: pulse, motor_reverse: rev, torque_enable: tq};
  endfunction

  function automatic plan_row_t row_tick(vdms_pkg::in_beat_t t);
    return '{ROW_TICK, t, '0, '0, '0};
  endfunction

  function automatic plan_row_t row_check(vdms_pkg::in_beat_t t, vdms_pkg::out_beat_t w);
    return '{ROW_CHECK, t, w, '0, '0};
  endfunction

  function automatic plan_row_t row_write(logic [vdms_pkg::CFG_IDX_W-1:0] i,
                                          logic [vdms_pkg::CFG_DATA_W-1:0] v);
    return '{ROW_WRITE, '0, '0, i, v};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch at out beat %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  // Offer one tick beat; hold it until taken, then predict its out beat.
  // Leave in_valid high afterwards so back-to-back beats follow without a gap.
  task automatic send_tick(input vdms_pkg::in_beat_t b, input logic typed,
                           input vdms_pkg::out_beat_t want);
    vdms_pkg::out_beat_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    step_sequencer(b, r);
    expected_drive.push_back(typed ? want : r);
    ticks_sent++;
  endtask

  // Drop valid and wait until every predicted out beat has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_drive.size() != 0);
  endtask

  task automatic write_reg(input logic [vdms_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vdms_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      vdms_pkg::CFG_TICK_PERIOD: period_ms  = val[vdms_pkg::PERIOD_W-1:0];
      vdms_pkg::CFG_HV_WAIT:     wait_ms    = val;
      vdms_pkg::CFG_HV_TIMEOUT:  timeout_ms = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
    writes_done++;
  endtask

  // One random tick in the drive modes: mostly clean press/release runs, some noise.
  task automatic drive_tick();
    logic bt;
    if (btn_run == 0) begin
      btn_level = !btn_level;
      btn_run   = $urandom_range(4, 1);
    end
    btn_run--;
    bt = ($urandom_range(9) == 0) ? 1'($urandom_range(1)) : btn_level;
    send_tick(tk(vdms_pkg::FAULT_NONE, $urandom_range(99) >= 15, bt, 1'($urandom_range(1))),
              1'b0, '0);
  endtask

  // Stall the out channel at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each taken out beat, field by field, with the oldest prediction.
  always @(posedge clk) begin
    vdms_pkg::out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_drive.size() == 0)
        report_mismatch("out beat with nothing expected", out_data, '0);
      else begin
        want = expected_drive.pop_front();
        if (out_data.mode_code !== want.mode_code)
          report_mismatch("mode_code", out_data.mode_code, want.mode_code);
        if (out_data.inverter_enable_pulse !== want.inverter_enable_pulse)
          report_mismatch("inverter_enable_pulse", out_data.inverter_enable_pulse,
                          want.inverter_enable_pulse);
        if (out_data.motor_reverse !== want.motor_reverse)
          report_mismatch("motor_reverse", out_data.motor_reverse, want.motor_reverse);
        if (out_data.torque_enable !== want.torque_enable)
          report_mismatch("torque_enable", out_data.torque_enable, want.torque_enable);
      end
    end
  end

  initial begin
    int n;
    logic [1:0] f;

    // Startup: init ignores status, undecided codes hold lv_startup, clean status moves on.
    plan.push_back(row_check(tk(FAULT_ODD, 1, 1, 1),
                             ob(vdms_pkg::MODE_LV_STARTUP, 0, 0, 0)));
    plan.push_back(row_check(tk(FAULT_UNDECIDED, 0, 1, 0),
                             ob(vdms_pkg::MODE_LV_STARTUP, 0, 0, 0)));
    plan.push_back(row_check(tk(FAULT_ODD, 0, 0, 1),
                             ob(vdms_pkg::MODE_LV_STARTUP, 0, 0, 0)));
    plan.push_back(row_check(tk(vdms_pkg::FAULT_NONE, 1, 1, 1),
                             ob(vdms_pkg::MODE_LV_READY, 0, 0, 0)));
    // lv_ready: a press with unreadable sense data is ignored.
    plan.push_back(row_tick(tk(vdms_pkg::FAULT_NONE, 0, 1, 1)));
    plan.push_back(row_tick(tk(vdms_pkg::FAULT_NONE, 1, 0, 0)));
    // Zero tick period, then a write to the unused index, which must change nothing.
    plan.push_back(row_write(vdms_pkg::CFG_TICK_PERIOD, 16'd0));
    plan.push_back(row_write(CFG_UNUSED, 16'hFFFF));
    plan.push_back(row_check(tk(vdms_pkg::FAULT_NONE, 1, 1, 0),
                             ob(vdms_pkg::MODE_HV_ACTIVE, 0, 0, 0)));
    plan.push_back(row_tick(tk(vdms_pkg::FAULT_NONE, 1, 1, 1)));
    // Longest wait with a period of 1000; the high bits of the period write are junk.
    plan.push_back(row_write(vdms_pkg::CFG_HV_WAIT, 16'hFFFF));
    plan.push_back(row_write(vdms_pkg::CFG_TICK_PERIOD, 16'hFFE8));
    plan.push_back(row_tick(tk(vdms_pkg::FAULT_NONE, 0, 0, 0)));
    // Zero wait with zero elapsed time: equal counts as done, so charging starts.
    plan.push_back(row_write(vdms_pkg::CFG_TICK_PERIOD, 16'd0));
    plan.push_back(row_write(vdms_pkg::CFG_HV_WAIT, 16'd0));
    plan.push_back(row_check(tk(vdms_pkg::FAULT_NONE, 0, 1, 0),
                             ob(vdms_pkg::MODE_HV_CHARGING, 1, 0, 0)));
    // Charging: elapsed equal to a zero timeout is not yet a timeout.
    plan.push_back(row_write(vdms_pkg::CFG_HV_TIMEOUT, 16'd0));
    plan.push_back(row_tick(tk(vdms_pkg::FAULT_NONE, 1, 0, 0)));
    // Past the timeout, but unreadable sense data holds the mode; then ready wins.
    plan.push_back(row_write(vdms_pkg::CFG_TICK_PERIOD, 16'd1));
    plan.push_back(row_check(tk(vdms_pkg::FAULT_NONE, 0, 1, 1),
                             ob(vdms_pkg::MODE_HV_CHARGING, 0, 0, 0)));
    plan.push_back(row_check(tk(vdms_pkg::FAULT_NONE, 1, 1, 1),
                             ob(vdms_pkg::MODE_NEUTRAL, 0, 0, 0)));
    // Neutral: the button history survives a tick with unreadable sense data.
    plan.push_back(row_tick(tk(vdms_pkg::FAULT_NONE, 0, 0, 0)));
    plan.push_back(row_tick(tk(vdms_pkg::FAULT_NONE, 1, 1, 0)));
    plan.push_back(row_tick(tk(vdms_pkg::FAULT_NONE, 1, 0, 1)));
    plan.push_back(row_tick(tk(vdms_pkg::FAULT_NONE, 1, 1, 0)));
    plan.push_back(row_write(vdms_pkg::CFG_HV_TIMEOUT, 16'hFFFF));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_WRITE: begin
          drain_results();
          write_reg(plan[i].idx, plan[i].val);
        end
        ROW_CHECK: send_tick(plan[i].tick, 1'b1, plan[i].want);
        default:   send_tick(plan[i].tick, 1'b0, '0);
      endcase
    end

    // Random drive cycles in three phases with their own idle rates, with fresh settings between them.
    for (int ph = 0; ph < 3; ph++) begin
      drain_results();
      case (ph)
        0: begin
          write_reg(vdms_pkg::CFG_TICK_PERIOD, 16'($urandom_range(1000, 1)));
          write_reg(vdms_pkg::CFG_HV_WAIT, 16'($urandom_range(65535)));
          write_reg(vdms_pkg::CFG_HV_TIMEOUT, 16'($urandom_range(65535)));
          write_reg(CFG_UNUSED, 16'($urandom_range(65535)));
          send_idle_pct = 24;
          recv_idle_pct = 47;
        end
        1: begin
          write_reg(vdms_pkg::CFG_TICK_PERIOD, 16'd1000);
          write_reg(vdms_pkg::CFG_HV_WAIT, 16'hFFFF);
          write_reg(vdms_pkg::CFG_HV_TIMEOUT, 16'hFFFF);
          send_idle_pct = 47;
          recv_idle_pct = 24;
        end
        default: begin
          write_reg(vdms_pkg::CFG_TICK_PERIOD, 16'd1);
          write_reg(vdms_pkg::CFG_HV_WAIT, 16'd0);
          write_reg(vdms_pkg::CFG_HV_TIMEOUT, 16'd0);
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (PHASE_TICKS) drive_tick();
    end

    // Walk into reverse so the fault lands with torque on, then stay in fault.
    while (cur_mode != vdms_pkg::MODE_REVERSE)
      send_tick(tk(vdms_pkg::FAULT_NONE, 1'b1, !prev_button, 1'($urandom_range(1))),
                1'b0, '0);
    f = 2'($urandom_range(3, 1));
    send_tick(tk(f, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1))),
              1'b0, '0);
    repeat (20)
      send_tick(tk(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1))), 1'b0, '0);

    in_valid <= 1'b0;
    for (n = 0; n < 5000 && expected_drive.size() != 0; n++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_drive.size() != 0)
      report_mismatch("predicted out beats never arrived", expected_drive.size(), 0);

    $display("covered %0d tick beats, %0d out beats compared, %0d register writes",
             ticks_sent, results_seen, writes_done);
    $display("predictor saw %0d mode changes, ending in mode %0d", mode_changes, cur_mode);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: end a hung run well past the slowest correct one.
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
rtl/vdms_pkg.sv
rtl/vdms_timer.sv
rtl/vdms_fsm.sv
rtl/vehicle_drive_mode_sequencer.sv
bench/tb_top.sv
